[rtl/ufr_pkg.sv]
// Shared types and constants for the frame receiver.
package ufr_pkg;

    // Payload buffer depth (bytes) and its address width
    localparam int PAYLOAD_DEPTH = 64;
    localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    // Command queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_END_BYTE   = 1'b1;

    localparam logic [7:0] START_BYTE_RST = 8'd170;
    localparam logic [7:0] END_BYTE_RST   = 8'd85;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SIZE_ERR = 2'd1,
        ST_SUM_ERR  = 2'd2,
        ST_END_ERR  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ID   = 3'd1,
        PH_SIZE = 3'd2,
        PH_DATA = 3'd3,
        PH_SUM  = 3'd4,
        PH_END  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_FETCH = 2'd1,
        BK_PUT   = 2'd2
    } back_state_t;

    // Frame-end command from the parser to the read-out side
    typedef struct packed {
        status_t    status;
        logic [7:0] id;
        logic [6:0] count;
    } cmd_t;

    // Payload buffer write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    // Queue fill status
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // One result word
    typedef struct packed {
        status_t    status;
        logic [7:0] id;
        logic [6:0] count;
        logic [5:0] index;
        logic [7:0] data;
        logic       last;
    } res_t;

endpackage

[rtl/ufr_front.sv]
// Frame parser: accepts received bytes, fills the payload buffer, queues frame ends.
module ufr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  ufr_pkg::q_stat_t   q_stat,
    input  logic               back_busy,
    output logic               push,
    output ufr_pkg::cmd_t      cmd,
    output ufr_pkg::mem_wr_t   mem_wr
);

    ufr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] id_reg, id_next;
    logic [6:0] size_reg, size_next;
    logic [6:0] fill_reg, fill_next;
    logic [7:0] start_byte_reg, end_byte_reg;
    logic       accept;
    logic [6:0] fill_inc;

    // Hold input while the queue is full, or in the payload phase while the buffer is still owed to read-out
    assign in_stall = q_stat.full
                   || ((phase_reg == ufr_pkg::PH_DATA) && (back_busy || !q_stat.empty));
    assign accept   = in_valid && !in_stall;
    assign fill_inc = fill_reg + 7'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= ufr_pkg::START_BYTE_RST;
            end_byte_reg   <= ufr_pkg::END_BYTE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ufr_pkg::REG_START_BYTE: start_byte_reg <= cfg_data;
                ufr_pkg::REG_END_BYTE:   end_byte_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                ufr_pkg::PH_ID:   phase_next = ufr_pkg::PH_SIZE;
                ufr_pkg::PH_SIZE:
                begin
                    if (rx_byte > 8'(ufr_pkg::PAYLOAD_DEPTH))
                        phase_next = ufr_pkg::PH_IDLE;
                    else if (rx_byte == 8'd0)
                        phase_next = ufr_pkg::PH_SUM;
                    else
                        phase_next = ufr_pkg::PH_DATA;
                end
                ufr_pkg::PH_DATA:
                begin
                    if (fill_inc >= size_reg)
                        phase_next = ufr_pkg::PH_SUM;
                end
                ufr_pkg::PH_SUM:
                begin
                    phase_next = (rx_byte == sum_reg) ? ufr_pkg::PH_END : ufr_pkg::PH_IDLE;
                end
                ufr_pkg::PH_END:  phase_next = ufr_pkg::PH_IDLE;
                default:
                begin
                    phase_next = (rx_byte == start_byte_reg) ? ufr_pkg::PH_ID
                                                             : ufr_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Datapath and outputs
    always_comb
    begin
        sum_next    = sum_reg;
        id_next     = id_reg;
        size_next   = size_reg;
        fill_next   = fill_reg;
        push        = 1'b0;
        cmd.status  = ufr_pkg::ST_OK;
        cmd.id      = id_reg;
        cmd.count   = size_reg;
        mem_wr.en   = 1'b0;
        mem_wr.addr = fill_reg[ufr_pkg::ADDR_W-1:0];
        mem_wr.data = rx_byte;
        if (accept)
        begin
            unique case (phase_reg)
                ufr_pkg::PH_ID:
                begin
                    id_next  = rx_byte;
                    sum_next = rx_byte;
                end
                ufr_pkg::PH_SIZE:
                begin
                    if (rx_byte > 8'(ufr_pkg::PAYLOAD_DEPTH))
                    begin
                        push       = 1'b1;
                        cmd.status = ufr_pkg::ST_SIZE_ERR;
                        cmd.count  = 7'd0;
                    end
                    else
                    begin
                        size_next = rx_byte[6:0];
                        sum_next  = sum_reg + rx_byte;
                    end
                end
                ufr_pkg::PH_DATA:
                begin
                    mem_wr.en = (fill_reg < 7'(ufr_pkg::PAYLOAD_DEPTH));
                    sum_next  = sum_reg + rx_byte;
                    fill_next = fill_inc;
                end
                ufr_pkg::PH_SUM:
                begin
                    if (rx_byte != sum_reg)
                    begin
                        push       = 1'b1;
                        cmd.status = ufr_pkg::ST_SUM_ERR;
                    end
                end
                ufr_pkg::PH_END:
                begin
                    push       = 1'b1;
                    cmd.status = (rx_byte != end_byte_reg) ? ufr_pkg::ST_END_ERR
                                                           : ufr_pkg::ST_OK;
                end
                default:
                begin
                    if (rx_byte == start_byte_reg)
                    begin
                        sum_next  = 8'd0;
                        fill_next = 7'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ufr_pkg::PH_IDLE;
            sum_reg   <= 8'd0;
            id_reg    <= 8'd0;
            size_reg  <= 7'd0;
            fill_reg  <= 7'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            id_reg    <= id_next;
            size_reg  <= size_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

[rtl/ufr_cmd_fifo.sv]
// Short queue of frame-end commands between parser and read-out.
module ufr_cmd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ufr_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output ufr_pkg::cmd_t    head,
    output ufr_pkg::q_stat_t q_stat
);

    ufr_pkg::cmd_t                entry_reg [ufr_pkg::QUEUE_DEPTH];
    logic [ufr_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [ufr_pkg::QCNT_W-1:0]   count_reg;
    logic                         do_push, do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == ufr_pkg::QCNT_W'(ufr_pkg::QUEUE_DEPTH));
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[rtl/ufr_back.sv]
// Read-out side: holds the payload buffer and turns frame-end commands into result words.
module ufr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ufr_pkg::mem_wr_t  mem_wr,
    input  ufr_pkg::cmd_t     head,
    input  ufr_pkg::q_stat_t  q_stat,
    output logic              pop,
    output logic              back_busy,
    output logic              out_valid,
    input  logic              out_stall,
    output ufr_pkg::res_t     res
);

    logic [7:0] mem [ufr_pkg::PAYLOAD_DEPTH];
    logic [7:0] rd_data_reg;

    ufr_pkg::back_state_t        state_reg, state_next;
    ufr_pkg::cmd_t               cmd_reg, cmd_next;
    logic [ufr_pkg::ADDR_W-1:0]  k_reg, k_next;
    logic                        out_valid_reg, out_valid_next;
    ufr_pkg::res_t               res_reg, res_next;
    logic                        out_free, head_single, k_last, load;

    assign out_free    = !out_valid_reg || !out_stall;
    assign head_single = (head.status != ufr_pkg::ST_OK) || (head.count == 7'd0);
    assign k_last      = ((7'(k_reg) + 7'd1) == cmd_reg.count);
    assign back_busy   = (state_reg != ufr_pkg::BK_IDLE);
    assign out_valid   = out_valid_reg;
    assign res         = res_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
            mem[mem_wr.addr] <= mem_wr.data;
        rd_data_reg <= mem[k_reg];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ufr_pkg::BK_IDLE:
            begin
                if (!q_stat.empty && out_free && !head_single)
                    state_next = ufr_pkg::BK_FETCH;
            end
            ufr_pkg::BK_FETCH: state_next = ufr_pkg::BK_PUT;
            ufr_pkg::BK_PUT:
            begin
                if (out_free)
                    state_next = k_last ? ufr_pkg::BK_IDLE : ufr_pkg::BK_FETCH;
            end
            default: state_next = ufr_pkg::BK_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        pop      = 1'b0;
        load     = 1'b0;
        cmd_next = cmd_reg;
        k_next   = k_reg;
        res_next = res_reg;
        unique case (state_reg)
            ufr_pkg::BK_IDLE:
            begin
                if (!q_stat.empty && out_free)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    k_next   = '0;
                    if (head_single)
                    begin
                        load           = 1'b1;
                        res_next.status = head.status;
                        res_next.id     = head.id;
                        res_next.count  = head.count;
                        res_next.index  = 6'd0;
                        res_next.data   = 8'd0;
                        res_next.last   = 1'b1;
                    end
                end
            end
            ufr_pkg::BK_PUT:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    res_next.status = ufr_pkg::ST_OK;
                    res_next.id     = cmd_reg.id;
                    res_next.count  = cmd_reg.count;
                    res_next.index  = 6'(k_reg);
                    res_next.data   = rd_data_reg;
                    res_next.last   = k_last;
                    k_next          = k_reg + 1'b1;
                end
            end
            default: ;
        endcase
        if (load)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ufr_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

endmodule

[rtl/uart_frame_receiver_unit.sv]
// Top level of the framed byte-stream receiver.
//
// Input channel: one received byte per word on rx_byte, taken at a clock edge
// with in_valid high and in_stall low. Frames are start, id, size, payload,
// checksum, end; bytes outside a frame are dropped.
// Output channel: result words (status, frame_id, payload_count, byte_index,
// payload_byte, last), taken when out_valid is high and out_stall low.
// A frame error gives one word; a good frame gives one word per payload byte
// (or one word for an empty payload), with last set on the final word.
// Configuration: cfg_we writes cfg_data to start byte (index 0) or end byte
// (index 1); write only while the block is idle.
// Throughput: one input byte per cycle while parsing and in_stall is low.
// Read-out makes each payload word by a buffer read, then an output register
// load; a single-word result is loaded from the queue head with no buffer read.
// The input holds (in_stall) when the two-entry command queue is full, and when
// payload bytes of a new frame arrive while an earlier frame is still queued or
// being read out of the shared buffer. When out_stall is high while out_valid is
// high, the output word holds and read-out pauses. Reset returns to waiting for a
// start byte, empties the queue and restores the default start and end bytes.
module uart_frame_receiver_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] frame_id,
    output logic [6:0] payload_count,
    output logic [5:0] byte_index,
    output logic [7:0] payload_byte,
    output logic       last,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    ufr_pkg::q_stat_t q_stat;
    ufr_pkg::cmd_t    push_cmd;
    ufr_pkg::cmd_t    head;
    ufr_pkg::mem_wr_t mem_wr;
    ufr_pkg::res_t    res;
    logic             push;
    logic             pop;
    logic             back_busy;

    // Parse bytes and fill the buffer
    ufr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .back_busy (back_busy),
        .push      (push),
        .cmd       (push_cmd),
        .mem_wr    (mem_wr)
    );

    // Decouple frame ends from read-out
    ufr_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // Emit result words
    ufr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mem_wr    (mem_wr),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .back_busy (back_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign status        = res.status;
    assign frame_id      = res.id;
    assign payload_count = res.count;
    assign byte_index    = res.index;
    assign payload_byte  = res.data;
    assign last          = res.last;

endmodule

[rtl/ufr_checker.sv]
// Port-level checks for the frame receiver, bound to the top level.
module ufr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [6:0] payload_count,
    input logic [5:0] byte_index,
    input logic [7:0] payload_byte,
    input logic       last
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(byte_index)
            && $stable(payload_byte) && $stable(last))
        else $error("stalled result word changed");

    // Error results stand alone
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ufr_pkg::ST_OK) |-> last && (payload_byte == 8'd0))
        else $error("error result not a single word");

    // Size error reports no payload
    a_size_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ufr_pkg::ST_SIZE_ERR) |-> (payload_count == 7'd0))
        else $error("size error with nonzero count");

    // Last payload word sits at the end of the payload
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && (status == ufr_pkg::ST_OK) && (payload_count != 7'd0)
            |-> ((7'(byte_index) + 7'd1) == payload_count))
        else $error("last flag at wrong byte index");

endmodule

bind uart_frame_receiver_unit ufr_checker u_ufr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .payload_count (payload_count),
    .byte_index    (byte_index),
    .payload_byte  (payload_byte),
    .last          (last)
);

[tb/uart_frame_receiver_unit_tb.sv]
// Self-checking testbench for the framed byte-stream receiver.
module uart_frame_receiver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ufr_pkg::*;

    // Give up well past the slowest legal run: long payload read-outs and
    // heavy idling on both sides.
    localparam int CYCLE_LIMIT = 200000;
    // Least number of bytes per random phase, counting frame bytes only (noise is dropped).
    localparam int PHASE_BYTES = 64;
    // Length of the receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES = 300;

    // One row of the directed table: a byte, and optionally the single result
    // word that it is known to close the frame with.
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        res_t       word;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] status;
    logic [7:0] frame_id;
    logic [6:0] payload_count;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       last;
    logic       cfg_we = 1'b0;
    logic       cfg_index = REG_START_BYTE;
    logic [7:0] cfg_data = 8'h00;

    // Idling knobs and the hold-off counter, read by the drive processes.
    int send_gap_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int fail_count = 0;
    int cycle_count = 0;

    // Shadow of the parser: framing bytes, phase, running checksum and buffer.
    logic [7:0] start_cfg;
    logic [7:0] end_cfg;
    phase_t     rx_phase;
    logic [7:0] rx_sum;
    logic [7:0] rx_id;
    logic [6:0] rx_size;
    logic [6:0] rx_fill;
    logic [7:0] rx_buf [PAYLOAD_DEPTH];

    res_t       frame_out[$];      // words caused by the latest byte
    res_t       pending_words[$];  // words still owed by the block, in order
    logic [7:0] frame_bytes[$];    // one generated frame

    dir_row_t   dir_rows [26];

    uart_frame_receiver_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .frame_id      (frame_id),
        .payload_count (payload_count),
        .byte_index    (byte_index),
        .payload_byte  (payload_byte),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL uart_frame_receiver_unit");
            $finish;
        end
    end

    // Receiver side: hold off for a counted stretch when asked, otherwise
    // stall at the rate of the current phase.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Sample mid-cycle: outputs and out_stall only move at the rising edge, so
    // a word seen here is the one taken at the next edge.
    always @(negedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word: status %0d id %0d index %0d",
                       status, frame_id, byte_index);
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("status", want.status, status);
                check_field("frame_id", want.id, frame_id);
                check_field("payload_count", want.count, payload_count);
                check_field("byte_index", want.index, byte_index);
                check_field("payload_byte", want.data, payload_byte);
                check_field("last", want.last, last);
            end
        end
    end

    function automatic res_t make_word(status_t st, logic [6:0] cnt, logic [5:0] idx,
                                       logic [7:0] data, logic fin);
        res_t w;
        w.status = st;
        w.id     = rx_id;
        w.count  = cnt;
        w.index  = idx;
        w.data   = data;
        w.last   = fin;
        return w;
    endfunction

    // Advance the shadow parser by one byte; collect the words it closes with.
    function automatic void parse_byte(logic [7:0] b);
        frame_out.delete();
        case (rx_phase)
            PH_ID:
            begin
                rx_id    = b;
                rx_sum   = b;
                rx_phase = PH_SIZE;
            end
            PH_SIZE:
            begin
                if (b > PAYLOAD_DEPTH)
                begin
                    // Oversized: one size error, back to hunting for a start byte.
                    frame_out.push_back(make_word(ST_SIZE_ERR, 7'd0, 6'd0, 8'd0, 1'b1));
                    rx_phase = PH_IDLE;
                end
                else
                begin
                    rx_size  = b[6:0];
                    rx_sum   = rx_sum + b;
                    rx_phase = (b == 0) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA:
            begin
                rx_buf[rx_fill[5:0]] = b;
                rx_sum  = rx_sum + b;
                rx_fill = rx_fill + 7'd1;
                if (rx_fill >= rx_size)
                    rx_phase = PH_SUM;
            end
            PH_SUM:
            begin
                if (b == rx_sum)
                    rx_phase = PH_END;
                else
                begin
                    frame_out.push_back(make_word(ST_SUM_ERR, rx_size, 6'd0, 8'd0, 1'b1));
                    rx_phase = PH_IDLE;
                end
            end
            PH_END:
            begin
                if (b != end_cfg)
                    frame_out.push_back(make_word(ST_END_ERR, rx_size, 6'd0, 8'd0, 1'b1));
                else if (rx_size == 0)
                    frame_out.push_back(make_word(ST_OK, 7'd0, 6'd0, 8'd0, 1'b1));
                else
                    for (int k = 0; k < rx_size; k++)
                        frame_out.push_back(make_word(ST_OK, rx_size, k[5:0], rx_buf[k],
                                                      k + 1 == rx_size));
                rx_phase = PH_IDLE;
            end
            default:
            begin
                // Hunting: drop everything but the start byte.
                if (b == start_cfg)
                begin
                    rx_sum   = 8'd0;
                    rx_fill  = 7'd0;
                    rx_phase = PH_ID;
                end
                else
                    rx_phase = PH_IDLE;
            end
        endcase
    endfunction

    // Offer one word on the input channel; return at the edge that takes it.
    // in_valid stays high on return so back-to-back words need no extra edge.
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
    endtask

    // Send a byte and queue what it should cause: the typed-in word where the
    // row gives one, otherwise the shadow parser's words.
    task automatic feed(logic [7:0] b, logic typed, res_t word);
        send_byte(b);
        parse_byte(b);
        if (typed)
            pending_words.push_back(word);
        else
            foreach (frame_out[i])
                pending_words.push_back(frame_out[i]);
    endtask

    // Drop valid, wait for every owed word, then let the read-out settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_START_BYTE)
            start_cfg = val;
        else
            end_cfg = val;
    endtask

    // Build one frame with random content. Most frames are well formed; the
    // rest carry an oversized length, a bad checksum or a bad closing byte.
    // Payload bytes sometimes repeat the start byte, which must not resync.
    task automatic build_frame();
        logic [7:0] id;
        logic [7:0] size;
        logic [7:0] sum;
        logic [7:0] b;
        int         kind;
        int         pick;
        kind = $urandom_range(99);
        pick = $urandom_range(99);
        id   = 8'($urandom);
        frame_bytes.delete();
        if (kind < 8)
            size = 8'($urandom_range(255, 65));
        else if (pick < 75)
            size = 8'($urandom_range(8, 0));
        else if (pick < 95)
            size = 8'($urandom_range(32, 9));
        else
            size = 8'(PAYLOAD_DEPTH);
        frame_bytes.push_back(start_cfg);
        frame_bytes.push_back(id);
        frame_bytes.push_back(size);
        if (kind >= 8)
        begin
            sum = id + size;
            for (int i = 0; i < size; i++)
            begin
                b = ($urandom_range(9) == 0) ? start_cfg : 8'($urandom);
                frame_bytes.push_back(b);
                sum = sum + b;
            end
            if (kind < 18)
                frame_bytes.push_back(sum ^ (8'd1 << $urandom_range(7)));
            else
            begin
                frame_bytes.push_back(sum);
                if (kind < 28)
                    frame_bytes.push_back(end_cfg ^ 8'($urandom_range(255, 1)));
                else
                    frame_bytes.push_back(end_cfg);
            end
        end
    endtask

    initial
    begin
        logic [7:0] noise;
        int         phase_items;

        // Directed frames under the reset framing (start 0xAA, end 0x55).
        dir_rows = '{
            // stray byte while hunting: dropped
            '{8'hFF, 1'b0, '0},
            // empty payload: one success word
            '{8'hAA, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h55, 1'b1, '{ST_OK, 8'h00, 7'd0, 6'd0, 8'h00, 1'b1}},
            // length just past the buffer depth
            '{8'hAA, 1'b0, '0}, '{8'hFF, 1'b0, '0},
            '{8'h41, 1'b1, '{ST_SIZE_ERR, 8'hFF, 7'd0, 6'd0, 8'h00, 1'b1}},
            // checksum off by one
            '{8'hAA, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h02, 1'b1, '{ST_SUM_ERR, 8'h01, 7'd0, 6'd0, 8'h00, 1'b1}},
            // start byte as payload, good checksum, wrong closing byte
            '{8'hAA, 1'b0, '0}, '{8'h03, 1'b0, '0}, '{8'h01, 1'b0, '0},
            '{8'hAA, 1'b0, '0}, '{8'hAE, 1'b0, '0},
            '{8'h00, 1'b1, '{ST_END_ERR, 8'h03, 7'd1, 6'd0, 8'h00, 1'b1}},
            // good two-byte frame, checksum wraps to zero
            '{8'hAA, 1'b0, '0}, '{8'h7F, 1'b0, '0}, '{8'h02, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h55, 1'b0, '0}
        };

        start_cfg = START_BYTE_RST;
        end_cfg   = END_BYTE_RST;
        rx_phase  = PH_IDLE;
        rx_sum    = 8'd0;
        rx_id     = 8'd0;
        rx_size   = 7'd0;
        rx_fill   = 7'd0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            feed(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].word);
        drain();

        // Random phases. Each one starts from an idle block with a fresh
        // framing setup and idling profile:
        //   0 reset framing, no idling, long receiver hold-off up front
        //   1 start 0x00 / end 0xFF, sender idles 57%
        //   2 start 0xFF / end 0x00, receiver stalls 57%
        //   3 random framing (sometimes start equals end), both idle 24%
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                    hold_left    = HOLD_CYCLES;
                end
                1:
                begin
                    write_reg(REG_START_BYTE, 8'h00);
                    write_reg(REG_END_BYTE, 8'hFF);
                    send_gap_pct = 57;
                    stall_pct    = 0;
                end
                2:
                begin
                    write_reg(REG_START_BYTE, 8'hFF);
                    write_reg(REG_END_BYTE, 8'h00);
                    send_gap_pct = 0;
                    stall_pct    = 57;
                end
                default:
                begin
                    write_reg(REG_START_BYTE, 8'($urandom));
                    write_reg(REG_END_BYTE, ($urandom_range(1) == 0) ? start_cfg
                                                                     : 8'($urandom));
                    send_gap_pct = 24;
                    stall_pct    = 24;
                end
            endcase

            phase_items = 0;
            while (phase_items < PHASE_BYTES)
            begin
                // Occasionally slip in bytes the hunter must drop.
                if ($urandom_range(4) == 0)
                    repeat ($urandom_range(3, 1))
                    begin
                        do
                            noise = 8'($urandom);
                        while (noise == start_cfg);
                        feed(noise, 1'b0, '0);
                    end
                build_frame();
                foreach (frame_bytes[i])
                    feed(frame_bytes[i], 1'b0, '0);
                phase_items += frame_bytes.size();
            end
            // Hold the sender until every owed word is out.
            drain();
        end

        if (fail_count == 0)
            $display("PASS uart_frame_receiver_unit");
        else
            $display("FAIL uart_frame_receiver_unit");
        $finish;
    end

endmodule

[sim.f]
rtl/ufr_pkg.sv
rtl/ufr_front.sv
rtl/ufr_cmd_fifo.sv
rtl/ufr_back.sv
rtl/uart_frame_receiver_unit.sv
rtl/ufr_checker.sv
tb/uart_frame_receiver_unit_tb.sv
